[sv/fp16_row_tag_accumulator_defines.svh]
// Assertion macros for the row-tag accumulator
`ifndef FP16_ROW_TAG_ACCUMULATOR_DEFINES_SVH
`define FP16_ROW_TAG_ACCUMULATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define FRTA_ASSERT(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define FRTA_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FRTA_ASSERT(label, clk, rstn, prop, msg)
`define FRTA_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

[sv/frta_pkg.sv]
// ----------------------------------------------------------------------------
// frta_pkg
// Shared types and constants for the row-tag accumulator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package frta_pkg;
  localparam logic [1:0] WHY_EVICT  = 2'd0;
  localparam logic [1:0] WHY_DRAIN  = 2'd1;
  localparam logic [1:0] WHY_REJECT = 2'd2;
  localparam int GROUP_BITS = 6;
  localparam int LIMIT_BITS = 17;
  localparam logic CFG_GROUP_ID  = 1'b0;
  localparam logic CFG_ROW_LIMIT = 1'b1;

  // Adder handshake: start pulse with operands, done with result
  typedef struct packed {
    logic        start;
    logic [15:0] a;
    logic [15:0] b;
  } add_req_t;

  typedef struct packed {
    logic        done;
    logic [15:0] sum;
  } add_rsp_t;
endpackage

[sv/frta_fp16_adder.sv]
// ----------------------------------------------------------------------------
// frta_fp16_adder
// Multi-cycle binary16 adder, round to nearest even; one step per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "fp16_row_tag_accumulator_defines.svh"
module frta_fp16_adder import frta_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  add_req_t req_i,
  output add_rsp_t rsp_o
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ALIGN = 3'd1;
  localparam logic [2:0] S_ADD = 3'd2;
  localparam logic [2:0] S_NORM = 3'd3;
  localparam logic [2:0] S_ROUND = 3'd4;

  logic [2:0] st_q, st_d;
  logic [15:0] a_q, b_q;
  logic [40:0] ma_q, mb_q, mag_q;
  logic        sign_q;
  logic [5:0]  p_q;
  logic [15:0] res_q;
  logic        spec_q;

  // Operand decode
  logic        sa, sb;
  logic [4:0]  ea, eb;
  logic [9:0]  fa, fb;
  assign sa = a_q[15]; assign sb = b_q[15];
  assign ea = a_q[14:10]; assign eb = b_q[14:10];
  assign fa = a_q[9:0]; assign fb = b_q[9:0];

  // Leading one search over the sum
  logic [5:0] lead;
  always_comb begin
    lead = 6'd0;
    for (int i = 0; i < 41; i++) if (mag_q[i]) lead = 6'(i);
  end

  // Rounding of the normalised mantissa
  logic [5:0]  shift;
  logic [40:0] mm, rem, half;
  logic [11:0] mr;
  logic [5:0]  ex;
  logic        up;
  always_comb begin
    shift = p_q - 6'd10;
    mm = mag_q >> shift;
    rem = mag_q & ((41'd1 << shift) - 41'd1);
    half = 41'd1 << (shift - 6'd1);
    up = (rem > half) || (rem == half && mm[0]);
    mr = mm[11:0] + {11'd0, up};
    ex = shift + 6'd1;
    if (mr == 12'd2048) begin
      mr = 12'd1024;
      ex = shift + 6'd2;
    end
  end

  always_comb begin
    st_d = st_q;
    case (st_q)
      S_IDLE:  if (req_i.start) st_d = S_ALIGN;
      S_ALIGN: st_d = spec_q ? S_IDLE : S_ADD;
      S_ADD:   st_d = S_NORM;
      S_NORM:  st_d = (mag_q < 41'd2048) ? S_IDLE : S_ROUND;
      S_ROUND: st_d = S_IDLE;
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) st_q <= S_IDLE;
    else st_q <= st_d;
  end

  // Datapath steps
  always_ff @(posedge clk_i) begin
    case (st_q)
      S_IDLE: begin
        a_q <= req_i.a;
        b_q <= req_i.b;
        spec_q <= (req_i.a[14:10] == 5'd31) || (req_i.b[14:10] == 5'd31);
      end
      S_ALIGN: begin
        if (ea == 5'd31 && fa != 10'd0) res_q <= a_q | 16'h0200;
        else if (eb == 5'd31 && fb != 10'd0) res_q <= b_q | 16'h0200;
        else if (ea == 5'd31 && eb == 5'd31) res_q <= (sa == sb) ? a_q : 16'h7E00;
        else if (ea == 5'd31) res_q <= a_q;
        else res_q <= b_q;
        ma_q <= {30'd0, (ea != 5'd0), fa} << ((ea != 5'd0) ? ea - 5'd1 : 5'd0);
        mb_q <= {30'd0, (eb != 5'd0), fb} << ((eb != 5'd0) ? eb - 5'd1 : 5'd0);
      end
      S_ADD: begin
        if (sa == sb) begin
          mag_q <= ma_q + mb_q; sign_q <= sa;
        end else if (ma_q >= mb_q) begin
          mag_q <= ma_q - mb_q; sign_q <= sa;
        end else begin
          mag_q <= mb_q - ma_q; sign_q <= sb;
        end
      end
      S_NORM: begin
        p_q <= lead;
        if (mag_q == 41'd0) res_q <= {sa & sb, 15'd0};
        else res_q <= {sign_q, mag_q[14:0]};
      end
      S_ROUND: begin
        if (ex >= 6'd31) res_q <= {sign_q, 15'h7C00};
        else res_q <= {sign_q, ex[4:0], mr[9:0]};
      end
      default: ;
    endcase
  end

  logic done_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_q <= 1'b0;
    else done_q <= (st_q != S_IDLE) && (st_d == S_IDLE);
  end
  assign rsp_o.done = done_q;
  assign rsp_o.sum = res_q;

  `FRTA_ASSERT(a_done_idle, clk_i, rst_ni, rsp_o.done |-> st_q == S_IDLE, "done while busy")
  `FRTA_ASSERT(a_no_start_busy, clk_i, rst_ni, st_q == S_ALIGN |-> $past(st_q) == S_IDLE, "bad entry")
  `FRTA_ASSERT(a_round_after_norm, clk_i, rst_ni, st_q == S_ROUND |-> $past(st_q) == S_NORM, "bad step")
endmodule

[sv/fp16_row_tag_accumulator.sv]
// ----------------------------------------------------------------------------
// fp16_row_tag_accumulator
// Row-tagged binary16 partial sum table with eviction and drain.
// ----------------------------------------------------------------------------
// Channel | Dir | Payload
// s_axis  | in  | tdata {source_group,value,row}, tuser mode
// m_axis  | out | tdata {contributions,seq,group,value,row}, tuser why, tlast last
// cfg     | in  | we/index/data: 0 group_id, 1 row_limit
//
// A reject loads the result register at the accepting edge.
// A merge scans the tags up to the match in slot k, starts the adder in S_ADD
// and waits for it; the adder ends at align (special), norm (small sum) or round.
// A new row scans all tags, searches for the first free slot and inserts;
// when full, it searches all slots for the oldest entry, evicts it and inserts.
// A drain finds and emits the oldest entry until a search finds the table empty.
// Reset clears valid bits and counters; a waiting result stalls the sequencer
// and holds s_axis_tready low until it is taken.
`timescale 1ns / 1ps
`include "fp16_row_tag_accumulator_defines.svh"
module fp16_row_tag_accumulator import frta_pkg::*; #(
  parameter int ENTRIES  = 16,
  parameter int ROW_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // row[15:0], value[31:16], source_group[37:32]
  input  logic        s_axis_tuser,  // mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [87:0] m_axis_tdata,  // row[15:0], value[31:16], group[37:32],
                                     // seq[69:38], contributions[85:70]
  output logic [1:0]  m_axis_tuser,  // why
  output logic        m_axis_tlast,  // last
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [16:0] cfg_data_i
);
  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam logic [3:0] S_IDLE = 4'd0, S_SCAN = 4'd1, S_FREE = 4'd2,
    S_OLD = 4'd3, S_EVICT = 4'd4, S_INS = 4'd5, S_ADD = 4'd6,
    S_WAIT = 4'd7, S_OUT = 4'd8, S_DOLD = 4'd9, S_DEMIT = 4'd10;

  logic [3:0] st_q, st_d;
  logic [GROUP_BITS-1:0] grp_q;
  logic [LIMIT_BITS-1:0] lim_q;
  logic [ENTRIES-1:0] vld_q;
  logic [ROW_BITS-1:0] erow_q [ENTRIES];
  logic [15:0] esum_q [ENTRIES];
  logic [31:0] eage_q [ENTRIES];
  logic [15:0] ecnt_q [ENTRIES];
  logic [31:0] age_q, seq_q;
  logic [CW-1:0] idx_q;
  logic [IW-1:0] best_q;
  logic [31:0] bdist_q;
  logic bfound_q;
  logic [15:0] row_q, val_q;
  logic [87:0] od_q;
  logic [1:0] why_q;
  logic ol_q, ov_q;
  add_req_t areq;
  add_rsp_t arsp;

  logic [IW-1:0] ix;
  logic [31:0] age_gap;
  logic [ROW_BITS-1:0] rowt;
  logic [15:0] in_row;
  assign ix = idx_q[IW-1:0];
  assign age_gap = age_q - eage_q[ix];
  assign rowt = ROW_BITS'(row_q);
  // Keep only the row bits the table stores
  assign in_row = 16'(ROW_BITS'(s_axis_tdata[15:0]));

  assign s_axis_tready = (st_q == S_IDLE) && !ov_q;
  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata = od_q;
  assign m_axis_tuser = why_q;
  assign m_axis_tlast = ol_q;
  assign areq.start = (st_q == S_ADD);
  assign areq.a = esum_q[best_q];
  assign areq.b = val_q;

  frta_fp16_adder u_add (.clk_i, .rst_ni, .req_i(areq), .rsp_o(arsp));

  logic last_idx;
  assign last_idx = (idx_q == CW'(ENTRIES - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; grp_q <= '0; lim_q <= 17'h10000; vld_q <= '0;
      age_q <= '0; seq_q <= '0; ov_q <= 1'b0; idx_q <= '0;
      best_q <= '0; bdist_q <= '0; bfound_q <= 1'b0;
      od_q <= '0; why_q <= WHY_EVICT; ol_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_GROUP_ID) grp_q <= cfg_data_i[5:0];
        else lim_q <= cfg_data_i;
      end
      if (ov_q && m_axis_tready) ov_q <= 1'b0;
      case (st_q)
        S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
          idx_q <= '0; bfound_q <= 1'b0;
          if (s_axis_tuser) st_q <= S_DOLD;
          else if (s_axis_tdata[37:32] != grp_q || {1'b0, in_row} >= lim_q) begin
            seq_q <= seq_q + 32'd1;
            od_q <= {2'b00, 16'd0, seq_q + 32'd1, grp_q, s_axis_tdata[31:16], in_row};
            why_q <= WHY_REJECT;
            ol_q <= 1'b1; ov_q <= 1'b1;
          end else st_q <= S_SCAN;
        end
        S_SCAN: begin
          if (vld_q[ix] && erow_q[ix] == rowt) begin
            best_q <= ix; st_q <= S_ADD;
          end else if (last_idx) begin
            idx_q <= '0; st_q <= S_FREE;
          end else idx_q <= idx_q + 1'b1;
        end
        S_FREE: begin
          if (!vld_q[ix]) begin
            best_q <= ix; st_q <= S_INS;
          end else if (last_idx) begin
            idx_q <= '0; st_q <= S_OLD;
          end else idx_q <= idx_q + 1'b1;
        end
        S_OLD, S_DOLD: begin
          if (vld_q[ix] && (!bfound_q || age_gap > bdist_q)) begin
            best_q <= ix; bdist_q <= age_gap; bfound_q <= 1'b1;
          end
          if (last_idx) st_q <= (st_q == S_OLD) ? S_EVICT : S_DEMIT;
          else idx_q <= idx_q + 1'b1;
        end
        S_EVICT: if (!ov_q) begin
          seq_q <= seq_q + 32'd1;
          od_q <= {2'b00, ecnt_q[best_q], seq_q + 32'd1, grp_q, esum_q[best_q],
                   16'(erow_q[best_q])};
          why_q <= WHY_EVICT;
          ol_q <= 1'b1; ov_q <= 1'b1; st_q <= S_INS;
        end
        S_INS: begin
          age_q <= age_q + 32'd1; vld_q[best_q] <= 1'b1; st_q <= S_IDLE;
        end
        S_ADD: st_q <= S_WAIT;
        S_WAIT: if (arsp.done) st_q <= S_IDLE;
        S_DEMIT: begin
          if (!bfound_q) st_q <= S_IDLE;
          else if (!ov_q) begin
            seq_q <= seq_q + 32'd1;
            od_q <= {2'b00, ecnt_q[best_q], seq_q + 32'd1, grp_q, esum_q[best_q],
                     16'(erow_q[best_q])};
            why_q <= WHY_DRAIN;
            ol_q <= ($countones(vld_q) == 1);
            ov_q <= 1'b1; vld_q[best_q] <= 1'b0;
            idx_q <= '0; bfound_q <= 1'b0; st_q <= S_DOLD;
          end
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

  // Input capture and entry payload writes
  always_ff @(posedge clk_i) begin
    if (st_q == S_IDLE && s_axis_tvalid && s_axis_tready) begin
      row_q <= in_row; val_q <= s_axis_tdata[31:16];
    end
    if (st_q == S_INS) begin
      erow_q[best_q] <= rowt; esum_q[best_q] <= val_q;
      eage_q[best_q] <= age_q + 32'd1; ecnt_q[best_q] <= 16'd1;
    end
    if (st_q == S_WAIT && arsp.done) begin
      esum_q[best_q] <= arsp.sum;
      if (ecnt_q[best_q] != 16'hFFFF) ecnt_q[best_q] <= ecnt_q[best_q] + 16'd1;
    end
  end

  `FRTA_ASSERT(a_ready_idle, clk_i, rst_ni, s_axis_tready |-> st_q == S_IDLE, "ready while busy")
  `FRTA_ASSERT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> $stable({m_axis_tuser, m_axis_tlast, m_axis_tdata}), "payload moved")
  `FRTA_ASSERT(a_seq_step, clk_i, rst_ni, $rose(m_axis_tvalid) |-> m_axis_tdata[69:38] == seq_q, "seq mismatch")
endmodule

[test/fp16_row_tag_accumulator_checker.sv]
// ----------------------------------------------------------------------------
// fp16_row_tag_accumulator_checker
// Watches the input, output and register channels of the row-tag accumulator,
// keeps its own copy of the tag table, predicts every emitted entry and
// compares each output transaction field by field with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module fp16_row_tag_accumulator_checker import frta_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // row[15:0], value[31:16], source_group[37:32]
  input  logic        s_axis_tuser,  // mode
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [87:0] m_axis_tdata,  // row[15:0], value[31:16], group[37:32],
                                     // seq[69:38], contributions[85:70]
  input  logic [1:0]  m_axis_tuser,  // why
  input  logic        m_axis_tlast,  // last
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [16:0] cfg_data_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          result_count_o
);
  localparam int SLOTS = 16;

  typedef struct packed {
    logic [15:0] row;
    logic [15:0] value;
    logic [5:0]  group;
    logic [1:0]  why;
    logic [31:0] seq;
    logic [15:0] count;
    logic        last;
  } entry_out_t;

  // Shadow table and registers
  logic [5:0]  grp_q;
  logic [16:0] limit_q;
  logic        tab_valid [SLOTS];
  logic [15:0] tab_row   [SLOTS];
  logic [15:0] tab_sum   [SLOTS];
  logic [31:0] tab_age   [SLOTS];
  logic [15:0] tab_count [SLOTS];
  logic [31:0] age_ctr;
  logic [31:0] seq_ctr;
  entry_out_t  emitted_q [$];
  int          fails;
  int          results;
  int          pending;

  assign fail_count_o   = fails;
  assign pending_o      = pending;
  assign result_count_o = results;

  // binary16 addition, round to nearest even
  function automatic logic [15:0] half_add(logic [15:0] a, logic [15:0] b);
    logic [4:0] ea, eb;
    logic [9:0] fa, fb;
    logic sa, sb, sgn;
    longint unsigned ma, mb, mag, m, rem, half;
    int p, sh, e;
    ea = a[14:10]; eb = b[14:10]; fa = a[9:0]; fb = b[9:0]; sa = a[15]; sb = b[15];
    if (ea == 5'd31 && fa != 0) return a | 16'h0200;
    if (eb == 5'd31 && fb != 0) return b | 16'h0200;
    if (ea == 5'd31 && eb == 5'd31) return (sa == sb) ? a : 16'h7E00;
    if (ea == 5'd31) return a;
    if (eb == 5'd31) return b;
    ma = (ea != 0) ? (longint'({1'b1, fa}) << (ea - 1)) : longint'(fa);
    mb = (eb != 0) ? (longint'({1'b1, fb}) << (eb - 1)) : longint'(fb);
    if (sa == sb) begin
      mag = ma + mb; sgn = sa;
    end else if (ma >= mb) begin
      mag = ma - mb; sgn = sa;
    end else begin
      mag = mb - ma; sgn = sb;
    end
    if (mag == 0) return {sa & sb, 15'd0};
    if (mag < 2048) return {sgn, mag[14:0]};
    p = 0;
    while (p < 63 && (mag >> (p + 1)) != 0) p++;
    sh = p - 10;
    m = mag >> sh;
    rem = mag & ((64'd1 << sh) - 1);
    half = 64'd1 << (sh - 1);
    if (rem > half || (rem == half && m[0])) m++;
    if (m == 2048) begin
      m = 1024; sh++;
    end
    e = sh + 1;
    if (e >= 31) return {sgn, 15'h7C00};
    return {sgn, e[4:0], m[9:0]};
  endfunction

  // Slot with the largest age distance, lower slot on a tie; -1 when empty
  function automatic int oldest_slot();
    int best;
    logic [31:0] best_d, d;
    best = -1; best_d = 0;
    for (int i = 0; i < SLOTS; i++) begin
      if (tab_valid[i]) begin
        d = age_ctr - tab_age[i];
        if (best < 0 || d > best_d) begin
          best = i; best_d = d;
        end
      end
    end
    return best;
  endfunction

  function automatic void push_entry(logic [15:0] r, logic [15:0] v, logic [1:0] why,
                                     logic [15:0] c, logic lst);
    entry_out_t x;
    seq_ctr++;
    x = '{row: r, value: v, group: grp_q, why: why, seq: seq_ctr, count: c, last: lst};
    emitted_q.insert(emitted_q.size(), x);
  endfunction

  // Apply one accepted input transaction to the shadow table
  function automatic void predict_item(logic mode, logic [15:0] row, logic [15:0] val,
                                       logic [5:0] src);
    int s, hit, freeslot, n;
    if (mode) begin
      s = oldest_slot();
      while (s >= 0) begin
        tab_valid[s] = 1'b0;
        n = oldest_slot();
        push_entry(tab_row[s], tab_sum[s], WHY_DRAIN, tab_count[s], n < 0);
        s = n;
      end
    end else if (src != grp_q || {1'b0, row} >= limit_q) begin
      push_entry(row, val, WHY_REJECT, 16'd0, 1'b1);
    end else begin
      hit = -1; freeslot = -1;
      for (int i = 0; i < SLOTS; i++) begin
        if (hit < 0 && tab_valid[i] && tab_row[i] == row) hit = i;
        if (freeslot < 0 && !tab_valid[i]) freeslot = i;
      end
      if (hit >= 0) begin
        tab_sum[hit] = half_add(tab_sum[hit], val);
        if (tab_count[hit] != 16'hFFFF) tab_count[hit]++;
      end else begin
        if (freeslot < 0) begin
          freeslot = oldest_slot();
          push_entry(tab_row[freeslot], tab_sum[freeslot], WHY_EVICT,
                     tab_count[freeslot], 1'b1);
        end
        age_ctr++;
        tab_valid[freeslot] = 1'b1;
        tab_row[freeslot]   = row;
        tab_sum[freeslot]   = val;
        tab_age[freeslot]   = age_ctr;
        tab_count[freeslot] = 16'd1;
      end
    end
  endfunction

  task automatic check_field(string name, longint unsigned exp, longint unsigned act);
    if (exp != act) begin
      fails++;
      $display("%0t: mismatch %s expected 0x%0h actual 0x%0h", $time, name, exp, act);
    end
  endtask

  // Track registers and inputs, compare outputs
  always @(posedge clk_i or negedge rst_ni) begin
    entry_out_t want;
    if (!rst_ni) begin
      grp_q   = '0;
      limit_q = 17'd65536;
      age_ctr = '0;
      seq_ctr = '0;
      for (int i = 0; i < SLOTS; i++) tab_valid[i] = 1'b0;
      emitted_q.delete();
      fails   = 0;
      results = 0;
      pending = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_GROUP_ID) grp_q = cfg_data_i[5:0];
        else if (cfg_index_i == CFG_ROW_LIMIT) limit_q = cfg_data_i;
      end
      if (s_axis_tvalid && s_axis_tready)
        predict_item(s_axis_tuser, s_axis_tdata[15:0], s_axis_tdata[31:16],
                     s_axis_tdata[37:32]);
      if (m_axis_tvalid && m_axis_tready) begin
        results++;
        if (emitted_q.size() == 0) begin
          fails++;
          $display("%0t: unexpected result expected none actual 0x%0h", $time, m_axis_tdata);
        end else begin
          want = emitted_q[0];
          emitted_q.delete(0);
          check_field("out_row",       want.row,   m_axis_tdata[15:0]);
          check_field("out_value",     want.value, m_axis_tdata[31:16]);
          check_field("out_group",     want.group, m_axis_tdata[37:32]);
          check_field("why",           want.why,   m_axis_tuser);
          check_field("seq_number",    want.seq,   m_axis_tdata[69:38]);
          check_field("contributions", want.count, m_axis_tdata[85:70]);
          check_field("last",          want.last,  m_axis_tlast);
        end
      end
      pending = emitted_q.size();
    end
  end
endmodule

[test/fp16_row_tag_accumulator_test.sv]
// ----------------------------------------------------------------------------
// fp16_row_tag_accumulator_test
// Drives directed and random partials and drains through the row-tag
// accumulator under several register settings, with bursty input and a
// stalling receiver; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module fp16_row_tag_accumulator_test;
  import frta_pkg::*;

  localparam int IDLE_LIMIT = 6000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;   // row[15:0], value[31:16], source_group[37:32]
  logic        s_axis_tuser = 1'b0; // mode
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [87:0] m_axis_tdata;        // row[15:0], value[31:16], group[37:32],
                                    // seq[69:38], contributions[85:70]
  logic [1:0]  m_axis_tuser;        // why
  logic        m_axis_tlast;        // last
  logic        cfg_we_i = 1'b0;
  logic        cfg_index_i = 1'b0;
  logic [16:0] cfg_data_i = '0;
  int          fail_count, pending, result_count;
  int          burst_left = 0;
  int          idle_cycles = 0;
  int          items_sent = 0;
  logic [5:0]  cur_group = '0;
  logic [16:0] cur_limit = 17'd65536;

  always #2 clk_i = ~clk_i;

  fp16_row_tag_accumulator dut (.*);

  fp16_row_tag_accumulator_checker u_checker (
    .fail_count_o(fail_count), .pending_o(pending), .result_count_o(result_count), .*
  );

  // Receiver stall pattern: free-running, random, and long-stall stretches
  int stall_phase = 0;
  always @(negedge clk_i) begin
    stall_phase <= stall_phase + 1;
    case ((stall_phase / 150) % 3)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= ($urandom_range(0, 1) == 1);
      default: m_axis_tready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // Watchdog on cycles with no transaction at all
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("[fp16_row_tag_accumulator] ERROR");
      $finish;
    end
  end

  task automatic send_item(logic mode, logic [15:0] row, logic [15:0] val, logic [5:0] src);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_axis_tvalid = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = mode;
    s_axis_tdata  = {2'b00, src, val, row};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    burst_left--;
    items_sent++;
  endtask

  // Hold until every result is in and any merge has settled
  task automatic settle();
    s_axis_tvalid = 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk_i);
    repeat (120) @(negedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [16:0] data);
    cfg_we_i = 1'b1; cfg_index_i = idx; cfg_data_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == CFG_GROUP_ID) cur_group = data[5:0];
    else cur_limit = data;
  endtask

  function automatic logic [15:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 16'(16'h7C00 | ($urandom_range(0, 1) << 15));
      1: return 16'(16'h7C00 | ($urandom_range(0, 1) << 15) | $urandom_range(1, 1023));
      2: return 16'($urandom_range(0, 1) << 15);
      3: return 16'(($urandom_range(0, 1) << 15) | $urandom_range(1, 1023));
      4: return 16'(16'h7BFF | ($urandom_range(0, 1) << 15));
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic random_phase(int count);
    int sel;
    logic [15:0] r;
    for (int k = 0; k < count; k++) begin
      sel = $urandom_range(0, 99);
      r = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(0, 65535)) :
          16'($urandom_range(0, 23) + (($urandom_range(0, 1) == 1) ? 16'hFFE0 : 16'h0));
      if (sel < 8)
        send_item(1'b1, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                  6'($urandom_range(0, 63)));
      else if (sel < 88)
        send_item(1'b0, r, pick_value(), cur_group);
      else
        send_item(1'b0, r, pick_value(), 6'($urandom_range(0, 63)));
    end
    send_item(1'b1, '0, '0, '0);
    settle();
  endtask

  initial begin
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: empty drain, merges, special sums, rejects
    send_item(1'b1, 16'hFFFF, 16'hFFFF, 6'h3F);
    send_item(1'b0, 16'h0000, 16'h3C00, 6'd0);
    send_item(1'b0, 16'h0000, 16'h3C00, 6'd0);
    send_item(1'b0, 16'hFFFF, 16'h7BFF, 6'd0);
    send_item(1'b0, 16'hFFFF, 16'h7BFF, 6'd0);
    send_item(1'b0, 16'h0001, 16'h7C00, 6'd0);
    send_item(1'b0, 16'h0001, 16'hFC00, 6'd0);
    send_item(1'b0, 16'h0002, 16'h8000, 6'd0);
    send_item(1'b0, 16'h0002, 16'h8000, 6'd0);
    send_item(1'b0, 16'h0003, 16'h7D01, 6'd0);
    send_item(1'b0, 16'h0003, 16'h3C00, 6'd0);
    send_item(1'b0, 16'h0004, 16'h0001, 6'd0);
    send_item(1'b0, 16'h0004, 16'h8001, 6'd0);
    send_item(1'b0, 16'h0005, 16'h3C00, 6'h3F);
    send_item(1'b1, 16'h0000, 16'h0000, 6'd0);
    settle();
    write_reg(CFG_GROUP_ID, 17'd63);
    write_reg(CFG_ROW_LIMIT, 17'd10);
    send_item(1'b0, 16'd9, 16'h4000, 6'd63);
    send_item(1'b0, 16'd10, 16'h4000, 6'd63);
    send_item(1'b0, 16'd9, 16'h4000, 6'd0);
    send_item(1'b1, 16'd0, 16'd0, 6'd0);
    settle();
    write_reg(CFG_ROW_LIMIT, 17'd0);
    send_item(1'b0, 16'd0, 16'h3C00, 6'd63);
    settle();

    // Random phases across register settings
    write_reg(CFG_GROUP_ID, 17'd0);
    write_reg(CFG_ROW_LIMIT, 17'd65536);
    random_phase(40);
    write_reg(CFG_GROUP_ID, 17'($urandom_range(0, 63)));
    write_reg(CFG_ROW_LIMIT, 17'($urandom_range(1, 20)));
    random_phase(25);
    write_reg(CFG_GROUP_ID, 17'd63);
    write_reg(CFG_ROW_LIMIT, 17'd65535);
    random_phase(40);
    write_reg(CFG_GROUP_ID, 17'($urandom_range(0, 63)));
    write_reg(CFG_ROW_LIMIT, 17'($urandom_range(0, 131071)));
    random_phase(35);

    $display("run covered %0d input items and %0d results over several register settings",
             items_sent, result_count);
    $display("including rejects, evictions, drains and special binary16 sums");
    if (fail_count == 0 && pending == 0)
      $display("[fp16_row_tag_accumulator] OK");
    else
      $display("[fp16_row_tag_accumulator] ERROR");
    $finish;
  end
endmodule

[sim.f]
+incdir+sv
sv/frta_pkg.sv
sv/frta_fp16_adder.sv
sv/fp16_row_tag_accumulator.sv
test/fp16_row_tag_accumulator_checker.sv
test/fp16_row_tag_accumulator_test.sv
